@@ rtl/core/ksma_pkg.sv @@
// Package with key codes, character constants and symbol tables for the keypad decoder.
package ksma_pkg;

    localparam int KeyW  = 7;
    localparam int CodeW = 8;
    localparam int ModeW = 3;
    localparam int SymW  = 5;

    localparam logic [KeyW-1:0] KeyNone     = 7'd0;
    localparam logic [KeyW-1:0] KeyCtrl     = 7'd1;
    localparam logic [KeyW-1:0] KeyShift    = 7'd2;
    localparam logic [KeyW-1:0] KeyEsc      = 7'd3;
    localparam logic [KeyW-1:0] KeyLetterLo = 7'd4;
    localparam logic [KeyW-1:0] KeyLetterHi = 7'd29;
    localparam logic [KeyW-1:0] KeyDigitLo  = 7'd30;
    localparam logic [KeyW-1:0] KeyDigitHi  = 7'd39;
    localparam logic [KeyW-1:0] KeySymLo    = 7'd40;
    localparam logic [KeyW-1:0] KeySymHi    = 7'd61;
    localparam logic [KeyW-1:0] KeyDel      = 7'd62;
    localparam logic [KeyW-1:0] KeyClear    = 7'd63;
    localparam logic [KeyW-1:0] KeyRet      = 7'd64;
    localparam logic [KeyW-1:0] KeyTab      = 7'd65;

    localparam logic [ModeW-1:0] ModeNormal = 3'd0;
    localparam logic [ModeW-1:0] ModeShift  = 3'd1;
    localparam logic [ModeW-1:0] ModeCaps   = 3'd2;
    localparam logic [ModeW-1:0] ModeCtrl   = 3'd4;

    localparam logic [CodeW-1:0] ChNone      = 8'h00;
    localparam logic [CodeW-1:0] ChModifier  = 8'h01;
    localparam logic [CodeW-1:0] ChLowerA    = 8'h61;
    localparam logic [CodeW-1:0] ChUpperA    = 8'h41;
    localparam logic [CodeW-1:0] ChZero      = 8'h30;
    localparam logic [CodeW-1:0] ChBackspace = 8'h08;
    localparam logic [CodeW-1:0] ChNewline   = 8'h0A;
    localparam logic [CodeW-1:0] ChTab       = 8'h09;

    localparam logic [1:0] KindFixed = 2'd0;
    localparam logic [1:0] KindShift = 2'd1;
    localparam logic [1:0] KindCtrl  = 2'd2;

    function automatic logic [CodeW-1:0] sym_plain(input logic [SymW-1:0] idx);
        logic [CodeW-1:0] c;
        begin
            case (idx)
                5'd0:  c = 8'h2C;
                5'd1:  c = 8'h2E;
                5'd2:  c = 8'h3A;
                5'd3:  c = 8'h28;
                5'd4:  c = 8'h29;
                5'd5:  c = 8'h20;
                5'd6:  c = 8'h2F;
                5'd7:  c = 8'h2A;
                5'd8:  c = 8'h2D;
                5'd9:  c = 8'h2D;
                5'd10: c = 8'h2B;
                5'd11: c = 8'h3D;
                5'd12: c = 8'h3C;
                5'd13: c = 8'h3E;
                5'd14: c = 8'h22;
                5'd15: c = 8'h27;
                5'd16: c = 8'h3F;
                5'd17: c = 8'h3F;
                5'd18: c = 8'h7C;
                5'd19: c = 8'h5E;
                5'd20: c = 8'h0A;
                5'd21: c = 8'hB2;
                default: c = ChNone;
            endcase
            return c;
        end
    endfunction

    function automatic logic [CodeW-1:0] sym_shift(input logic [SymW-1:0] idx);
        logic [CodeW-1:0] c;
        begin
            case (idx)
                5'd0:  c = 8'h3B;
                5'd1:  c = 8'h3A;
                5'd2:  c = 8'h3A;
                5'd3:  c = 8'h5B;
                5'd4:  c = 8'h7B;
                5'd5:  c = 8'h5F;
                5'd6:  c = 8'h5C;
                5'd7:  c = 8'h22;
                5'd8:  c = 8'h5F;
                5'd9:  c = 8'h5F;
                5'd16: c = 8'h21;
                5'd17: c = 8'h21;
                5'd20: c = 8'h7E;
                default: c = sym_plain(idx);
            endcase
            return c;
        end
    endfunction

    function automatic logic [CodeW-1:0] sym_ctrl(input logic [SymW-1:0] idx);
        logic [CodeW-1:0] c;
        begin
            case (idx)
                5'd3:    c = 8'h5D;
                5'd4:    c = 8'h7D;
                default: c = ChNone;
            endcase
            return c;
        end
    endfunction

    function automatic logic [1:0] sym_kind(input logic [SymW-1:0] idx);
        logic [1:0] k;
        begin
            case (idx)
                5'd3, 5'd4: k = KindCtrl;
                5'd0, 5'd1, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd16, 5'd17, 5'd20:
                    k = KindShift;
                default: k = KindFixed;
            endcase
            return k;
        end
    endfunction

endpackage

@@ rtl/core/keypad_sticky_modifier_ascii.sv @@
// Top level of the keypad decoder with sticky shift, caps lock and ctrl.
//
// One key event word enters on the slave stream: s_axis_tdata[6:0] holds the
// key number. One result word leaves on the master stream for every accepted
// key: char_code, cursor_mode and cursor_mode_valid.
// A taken word sits in an input register, is decoded and written to the output
// register once that register is free, which raises m_axis_tvalid. The modifier
// flags change at the same edge that writes the output register.
// Throughput is one word per cycle while m_axis_tready stays high; the only loop
// is the three flag registers, which the combinational decode logic reads and writes.
// When the receiver holds m_axis_tready low, the output register keeps its
// word, the input register fills, and s_axis_tready then drops until the
// output drains. Nothing is lost or repeated across a stall.
// Synchronous active-low reset empties both registers and clears shift,
// caps lock and ctrl.
module keypad_sticky_modifier_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] key_number, [7] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] char_code, [10:8] cursor_mode,
                                        // [11] cursor_mode_valid, [15:12] zero
);

    logic                          r_in_valid;
    logic [ksma_pkg::KeyW-1:0]     r_key;
    logic                          r_out_valid;
    logic [ksma_pkg::CodeW-1:0]    r_code;
    logic [ksma_pkg::ModeW-1:0]    r_mode;
    logic                          r_mode_valid;
    logic                          r_shift;
    logic                          r_caps;
    logic                          r_ctrl;

    logic                          n_shift;
    logic                          n_caps;
    logic                          n_ctrl;
    logic [ksma_pkg::CodeW-1:0]    n_code;
    logic [ksma_pkg::ModeW-1:0]    n_mode;
    logic                          n_mode_valid;

    logic                          out_free;
    logic                          advance;
    logic                          upper;
    logic [ksma_pkg::KeyW-1:0]     letter_off;
    logic [ksma_pkg::KeyW-1:0]     digit_off;
    logic [ksma_pkg::KeyW-1:0]     sym_full;
    logic [ksma_pkg::SymW-1:0]     sym_idx;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign upper         = r_shift || r_caps;
    assign letter_off    = r_key - ksma_pkg::KeyLetterLo;
    assign digit_off     = r_key - ksma_pkg::KeyDigitLo;
    assign sym_full      = r_key - ksma_pkg::KeySymLo;
    assign sym_idx       = sym_full[ksma_pkg::SymW-1:0];

    always_comb begin
        n_shift      = r_shift;
        n_caps       = r_caps;
        n_ctrl       = r_ctrl;
        n_code       = ksma_pkg::ChNone;
        n_mode       = ksma_pkg::ModeNormal;
        n_mode_valid = 1'b0;
        if (r_key == ksma_pkg::KeyCtrl) begin
            n_code       = ksma_pkg::ChModifier;
            n_mode_valid = 1'b1;
            n_ctrl       = !r_ctrl;
            n_mode       = r_ctrl ? ksma_pkg::ModeNormal : ksma_pkg::ModeCtrl;
        end else if (r_key == ksma_pkg::KeyShift) begin
            n_code       = ksma_pkg::ChModifier;
            n_mode_valid = 1'b1;
            if (r_ctrl) begin
                n_ctrl  = 1'b0;
                n_shift = 1'b0;
                n_caps  = 1'b1;
                n_mode  = ksma_pkg::ModeCaps;
            end else if (r_caps) begin
                n_caps = 1'b0;
            end else if (r_shift) begin
                n_shift = 1'b0;
            end else begin
                n_shift = 1'b1;
                n_mode  = ksma_pkg::ModeShift;
            end
        end else begin
            if (r_caps) begin
                n_mode       = ksma_pkg::ModeCaps;
                n_mode_valid = 1'b1;
            end
            if (r_key >= ksma_pkg::KeyLetterLo && r_key <= ksma_pkg::KeyLetterHi) begin
                n_code  = (upper ? ksma_pkg::ChUpperA : ksma_pkg::ChLowerA)
                          + {1'b0, letter_off};
                n_shift = 1'b0;
            end else if (r_key >= ksma_pkg::KeyDigitLo && r_key <= ksma_pkg::KeyDigitHi) begin
                n_code = ksma_pkg::ChZero + {1'b0, digit_off};
            end else if (r_key >= ksma_pkg::KeySymLo && r_key <= ksma_pkg::KeySymHi) begin
                case (ksma_pkg::sym_kind(sym_idx))
                    ksma_pkg::KindCtrl: begin
                        if (upper) begin
                            n_code  = ksma_pkg::sym_shift(sym_idx);
                            n_shift = 1'b0;
                        end else if (r_ctrl) begin
                            n_code = ksma_pkg::sym_ctrl(sym_idx);
                            n_ctrl = 1'b0;
                        end else begin
                            n_code = ksma_pkg::sym_plain(sym_idx);
                        end
                    end
                    ksma_pkg::KindShift: begin
                        n_code  = upper ? ksma_pkg::sym_shift(sym_idx)
                                        : ksma_pkg::sym_plain(sym_idx);
                        n_shift = 1'b0;
                    end
                    default: begin
                        n_code = ksma_pkg::sym_plain(sym_idx);
                    end
                endcase
            end else if (r_key == ksma_pkg::KeyDel || r_key == ksma_pkg::KeyClear) begin
                n_code = ksma_pkg::ChBackspace;
            end else if (r_key == ksma_pkg::KeyRet) begin
                n_code = ksma_pkg::ChNewline;
            end else if (r_key == ksma_pkg::KeyTab) begin
                n_code = ksma_pkg::ChTab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
            r_ctrl      <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_shift     <= n_shift;
                r_caps      <= n_caps;
                r_ctrl      <= n_ctrl;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_key <= s_axis_tdata[ksma_pkg::KeyW-1:0];
        end
        if (advance) begin
            r_code       <= n_code;
            r_mode       <= n_mode;
            r_mode_valid <= n_mode_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_mode_valid, r_mode, r_code};

    a_shift_caps_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_shift && r_caps))
        else $error("shift and caps lock set together");

    a_mode_zero_when_unwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_mode_valid) |-> (r_mode == ksma_pkg::ModeNormal))
        else $error("cursor mode nonzero without valid");

    a_ctrl_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_key == ksma_pkg::KeyCtrl) |=> (r_ctrl != $past(r_ctrl)))
        else $error("ctrl key did not toggle ctrl flag");

    a_modifier_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_key == ksma_pkg::KeyCtrl || r_key == ksma_pkg::KeyShift))
        |=> (r_code == ksma_pkg::ChModifier && r_mode_valid))
        else $error("modifier key result malformed");

    a_stall_holds_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_shift) && $stable(r_caps) && $stable(r_ctrl)))
        else $error("flags changed without an advancing word");

endmodule
